// File: sv/tea_pkg.sv
// tea_pkg: shared types, constants and lookup tables of the tilt echo beam aimer
// used by every design module of the block; depends on nothing

package tea_pkg;

    // field widths
    localparam int WidthW   = 16;
    localparam int IntervW  = 4;
    localparam int TiltW    = 14;
    localparam int YawMoveW = 6;
    localparam int PitchMvW = 4;
    localparam int YawTgtW  = 5;
    localparam int PitchTgW = 3;
    localparam int CfgIdxW  = 3;
    localparam int TblIdxW  = 4;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] RegNearOne  = 3'd0;
    localparam logic [CfgIdxW-1:0] RegFarOne   = 3'd1;
    localparam logic [CfgIdxW-1:0] RegNearTwo  = 3'd2;
    localparam logic [CfgIdxW-1:0] RegFarTwo   = 3'd3;
    localparam logic [CfgIdxW-1:0] RegInterval = 3'd4;

    // configuration reset values, tenths of cm
    localparam logic [WidthW-1:0]  NearOneRst  = 16'd300;
    localparam logic [WidthW-1:0]  FarOneRst   = 16'd1500;
    localparam logic [WidthW-1:0]  NearTwoRst  = 16'd550;
    localparam logic [WidthW-1:0]  FarTwoRst   = 16'd1500;
    localparam logic [IntervW-1:0] IntervalRst = 4'd4;

    // sensor selector codes
    localparam logic SensorOne = 1'b0;
    localparam logic SensorTwo = 1'b1;

    // divide by ten: (x * 0xCCCD) >> 19 is exact for any 16-bit x
    localparam logic [WidthW-1:0] RecipTen   = 16'hCCCD;
    localparam int                RecipShift = 19;
    localparam int                QuotW      = 13;

    // largest tilt that moves the aim, and the table center (tilt zero)
    localparam logic [QuotW-1:0]   TiltMax    = 13'd5;
    localparam logic [TblIdxW-1:0] TblCenter  = 4'd5;

    // aim targets indexed by tilt + 5
    localparam logic signed [YawTgtW-1:0] YawTable [0:10] = '{
        -5'sd10, -5'sd8, -5'sd6, -5'sd4, -5'sd2, 5'sd0,
        5'sd2, 5'sd4, 5'sd6, 5'sd8, 5'sd10
    };
    localparam logic [PitchTgW-1:0] PitchTable [0:10] = '{
        3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5
    };

    typedef struct packed {
        logic [WidthW-1:0]  near_one;
        logic [WidthW-1:0]  far_one;
        logic [WidthW-1:0]  near_two;
        logic [WidthW-1:0]  far_two;
        logic [IntervW-1:0] interval;
    } cfg_t;

    typedef struct packed {
        logic              mode;
        logic [WidthW-1:0] width;
    } item_t;

    typedef struct packed {
        logic              good;
        logic [WidthW-1:0] held_one;
        logic [WidthW-1:0] held_two;
    } sample_t;

    typedef struct packed {
        logic                       aim_update;
        logic signed [YawMoveW-1:0] yaw_move;
        logic signed [PitchMvW-1:0] pitch_move;
        logic signed [TiltW-1:0]    tilt_value;
        logic                       sample_good;
    } result_t;

endpackage

// File: sv/tilt_echo_beam_aimer.sv
// tilt_echo_beam_aimer: top level with config registers, input and result registers
// depends on tea_pkg, tea_sample_check and tea_aim_calc
//
//   channel   direction  beat contents
//   s_axis    in         tuser: mode; tdata: pulse_count
//   m_axis    out        tuser: aim_update, sample_good; tdata: yaw, pitch, tilt
//   cfg       in         one register write per cycle, no read-back
//
// one beat per cycle sustained while m_tready holds; a beat taken into the input register
// moves on to the result register once the result slot frees.
// the single pass between those two registers is set by the 16x16 reciprocal
// multiply of the divide by ten. synchronous active-low reset clears the held
// widths, counter and targets and reloads the config defaults. a stall on m_
// holds the result and fills the input register, after which s_tready drops.

module tilt_echo_beam_aimer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // [15:0] pulse_count
    input  logic [0:0]                    s_tuser,   // [0] mode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,   // [5:0] yaw_move, [9:6] pitch_move,
                                                     // [23:10] tilt_value
    output logic [1:0]                    m_tuser,   // [0] aim_update, [1] sample_good
    input  logic                          cfg_wr_en,
    input  logic [tea_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [tea_pkg::WidthW-1:0]    cfg_wdata
);

    tea_pkg::cfg_t    cfg_reg;
    tea_pkg::item_t   item_reg;
    logic             item_valid_reg, item_valid_next;
    tea_pkg::result_t res_reg;
    tea_pkg::result_t res_calc;
    logic             res_valid_reg, res_valid_next;
    tea_pkg::sample_t sample;
    logic             advance;
    logic             s_take;

    // configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.near_one <= tea_pkg::NearOneRst;
            cfg_reg.far_one  <= tea_pkg::FarOneRst;
            cfg_reg.near_two <= tea_pkg::NearTwoRst;
            cfg_reg.far_two  <= tea_pkg::FarTwoRst;
            cfg_reg.interval <= tea_pkg::IntervalRst;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                tea_pkg::RegNearOne:  cfg_reg.near_one <= cfg_wdata;
                tea_pkg::RegFarOne:   cfg_reg.far_one  <= cfg_wdata;
                tea_pkg::RegNearTwo:  cfg_reg.near_two <= cfg_wdata;
                tea_pkg::RegFarTwo:   cfg_reg.far_two  <= cfg_wdata;
                tea_pkg::RegInterval: cfg_reg.interval <= cfg_wdata[tea_pkg::IntervW-1:0];
                default: ;
            endcase
        end
    end

    // handshake: the beat in the input register moves on when the result slot frees
    assign advance  = item_valid_reg && (!res_valid_reg || m_tready);
    assign s_tready = !item_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_comb begin
        item_valid_next = item_valid_reg;
        if (s_take) begin
            item_valid_next = 1'b1;
        end else if (advance) begin
            item_valid_next = 1'b0;
        end
        res_valid_next = res_valid_reg;
        if (advance) begin
            res_valid_next = 1'b1;
        end else if (m_tready) begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end else begin
            item_valid_reg <= item_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // input and result payload registers
    always_ff @(posedge aclk) begin
        if (s_take) begin
            item_reg.mode  <= s_tuser[0];
            item_reg.width <= s_tdata;
        end
        if (advance) begin
            res_reg <= res_calc;
        end
    end

    tea_sample_check u_sample (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .sample  (sample)
    );

    tea_aim_calc u_aim (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (advance),
        .mode     (item_reg.mode),
        .sample   (sample),
        .interval (cfg_reg.interval),
        .result   (res_calc)
    );

    // result beat packing
    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {res_reg.tilt_value, res_reg.pitch_move, res_reg.yaw_move};
    assign m_tuser  = {res_reg.sample_good, res_reg.aim_update};

endmodule

// File: sv/tea_sample_check.sv
// tea_sample_check: window check of each echo width and the two held widths
// depends on tea_pkg

module tea_sample_check (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           step,
    input  tea_pkg::item_t item,
    input  tea_pkg::cfg_t  cfg,
    output tea_pkg::sample_t sample
);

    logic [tea_pkg::WidthW-1:0] held_one_reg, held_one_next;
    logic [tea_pkg::WidthW-1:0] held_two_reg, held_two_next;
    logic good;

    // strict window compare against the measuring sensor's limits
    always_comb begin
        if (item.mode == tea_pkg::SensorOne) begin
            good = (item.width > cfg.near_one) && (item.width < cfg.far_one);
        end else begin
            good = (item.width > cfg.near_two) && (item.width < cfg.far_two);
        end
        held_one_next = held_one_reg;
        held_two_next = held_two_reg;
        if (good && item.mode == tea_pkg::SensorOne) begin
            held_one_next = item.width;
        end
        if (good && item.mode == tea_pkg::SensorTwo) begin
            held_two_next = item.width;
        end
    end

    // held widths as they stand after this beat
    assign sample.good     = good;
    assign sample.held_one = held_one_next;
    assign sample.held_two = held_two_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_one_reg <= '0;
            held_two_reg <= '0;
        end else if (step) begin
            held_one_reg <= held_one_next;
            held_two_reg <= held_two_next;
        end
    end

endmodule

// File: sv/tea_aim_calc.sv
// tea_aim_calc: tilt from the held widths, update pacing counter and step moves
// depends on tea_pkg

module tea_aim_calc (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic                          mode,
    input  tea_pkg::sample_t              sample,
    input  logic [tea_pkg::IntervW-1:0]   interval,
    output tea_pkg::result_t              result
);

    logic signed [tea_pkg::WidthW:0]         diff;
    logic [tea_pkg::WidthW-1:0]              mag;
    logic [2*tea_pkg::WidthW-1:0]            prod;
    logic [tea_pkg::QuotW-1:0]               quot;
    logic signed [tea_pkg::TiltW-1:0]        tilt;
    logic                                    in_range;
    logic [tea_pkg::TblIdxW-1:0]             tbl_idx;
    logic signed [tea_pkg::YawTgtW-1:0]      yaw_tgt;
    logic [tea_pkg::PitchTgW-1:0]            pitch_tgt;
    logic [tea_pkg::IntervW-1:0]             count_reg, count_next, count_inc;
    logic signed [tea_pkg::YawTgtW-1:0]      yaw_reg, yaw_next;
    logic [tea_pkg::PitchTgW-1:0]            pitch_reg, pitch_next;
    logic                                    evaluate;
    logic                                    update;

    // signed difference, magnitude, divide by ten, sign restored (toward zero)
    always_comb begin
        diff = $signed({1'b0, sample.held_one}) - $signed({1'b0, sample.held_two});
        mag  = diff[tea_pkg::WidthW] ? tea_pkg::WidthW'(-diff)
                                     : diff[tea_pkg::WidthW-1:0];
        prod = mag * tea_pkg::RecipTen;
        quot = prod[tea_pkg::RecipShift +: tea_pkg::QuotW];
        tilt = diff[tea_pkg::WidthW] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    end

    // target lookup for tilt magnitudes one to five
    always_comb begin
        in_range  = (quot != '0) && (quot <= tea_pkg::TiltMax);
        tbl_idx   = diff[tea_pkg::WidthW] ? tea_pkg::TblCenter - quot[tea_pkg::TblIdxW-1:0]
                                          : tea_pkg::TblCenter + quot[tea_pkg::TblIdxW-1:0];
        yaw_tgt   = in_range ? tea_pkg::YawTable[tbl_idx] : '0;
        pitch_tgt = in_range ? tea_pkg::PitchTable[tbl_idx] : '0;
    end

    // pacing counter for sensor-two beats
    always_comb begin
        count_inc  = count_reg + 1'b1;
        evaluate   = (mode == tea_pkg::SensorTwo) &&
                     ((count_inc >= interval) || (count_reg >= interval));
        count_next = count_reg;
        if (mode == tea_pkg::SensorTwo) begin
            count_next = evaluate ? '0 : count_inc;
        end
        update     = evaluate && in_range;
        yaw_next   = update ? yaw_tgt : yaw_reg;
        pitch_next = update ? pitch_tgt : pitch_reg;
    end

    // moves relative to the previous targets
    always_comb begin
        result.aim_update  = update;
        result.yaw_move    = update ? ({yaw_tgt[tea_pkg::YawTgtW-1], yaw_tgt} -
                                       {yaw_reg[tea_pkg::YawTgtW-1], yaw_reg}) : '0;
        result.pitch_move  = update ? ($signed({1'b0, pitch_tgt}) -
                                       $signed({1'b0, pitch_reg})) : '0;
        result.tilt_value  = tilt;
        result.sample_good = sample.good;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            yaw_reg   <= '0;
            pitch_reg <= '0;
        end else if (step) begin
            count_reg <= count_next;
            yaw_reg   <= yaw_next;
            pitch_reg <= pitch_next;
        end
    end

endmodule

// File: sv/tea_checker.sv
// tea_checker: port-level checks on the aimer's result channel, bound to the top
// depends on tilt_echo_beam_aimer ports only

module tea_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // no result beat right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat present after reset");

    // a stalled result beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    // without an aim update both moves are zero
    a_idle_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[9:0] == 10'd0)
        else $error("moves nonzero without aim update");

    // an aim update only comes with a tilt of magnitude one to five
    a_update_tilt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            ($signed(m_tdata[23:10]) >= 14'sd1 && $signed(m_tdata[23:10]) <= 14'sd5) ||
            ($signed(m_tdata[23:10]) >= -14'sd5 && $signed(m_tdata[23:10]) <= -14'sd1))
        else $error("aim update with tilt out of range");

endmodule

bind tilt_echo_beam_aimer tea_checker u_tea_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
